// ===== rtl/core/prfc_pkg.sv =====
// Shared types, widths, reset values and codes for the PWM frequency ramp controller.
// No dependencies; prfc_ramp and the top level import this package.
package prfc_pkg;

	localparam int TIMER_CLOCK_HZ_DEF = 1000000;

	localparam int FREQ_W   = 16;
	localparam int PERIOD_W = 20;
	localparam int DUTY_W   = 7;
	localparam int STEP_W   = 8;
	localparam int TICK_W   = 8;
	localparam int STATE_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FREQ_W-1:0]   LOW_FREQ_RST  = 16'd4000;
	localparam logic [FREQ_W-1:0]   HIGH_FREQ_RST = 16'd8000;
	localparam logic [STEP_W-1:0]   RAMP_STEP_RST = 8'd8;
	localparam logic [TICK_W-1:0]   TICKS_RST     = 8'd10;
	localparam logic [DUTY_W-1:0]   DUTY_MAX      = 7'd100;
	localparam logic [FREQ_W-1:0]   PCT_DIVISOR   = 16'd100;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 20'hFFFFF;
	localparam logic [FREQ_W-1:0]   FREQ_MAX      = 16'hFFFF;

	// Ramp machine states.
	localparam logic [STATE_W-1:0] RS_LOW  = 2'd0;
	localparam logic [STATE_W-1:0] RS_HIGH = 2'd1;
	localparam logic [STATE_W-1:0] RS_DOWN = 2'd2;
	localparam logic [STATE_W-1:0] RS_UP   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_FREQ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FREQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 2'd3;

	typedef struct packed {
		logic [FREQ_W-1:0] floor_freq;
		logic [FREQ_W-1:0] ceiling_freq;
		logic [STEP_W-1:0] ramp_step;
		logic [TICK_W-1:0] ticks_per_update;
	} cfg_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [STATE_W-1:0] state;
		logic [FREQ_W-1:0]  switches;
		logic               req;
		logic               updated;
	} ramp_stat_t;

endpackage

// ===== rtl/core/prfc_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on nothing but its parameters.
module prfc_serial_mul #(
	parameter int AW = 20,
	parameter int BW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic            done,
	output logic [AW+BW-1:0] product
);
	localparam int CW = $clog2(BW + 1);

	logic [AW-1:0]    a_q;
	logic [BW-1:0]    b_q;
	logic [AW+BW-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(BW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[AW+BW-2:0], 1'b0} + (b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0);
			b_q   <= {b_q[BW-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/core/prfc_serial_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module prfc_serial_div #(
	parameter int DW = 27,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q[VW-1:0], quo_q[DW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/prfc_ramp.sv =====
// Tick divider and four-state frequency ramp machine.
// Depends on prfc_pkg for the configuration and status structs and state codes.
module prfc_ramp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                is_request,
	input  prfc_pkg::cfg_t      cfg,
	output prfc_pkg::ramp_stat_t stat
);
	import prfc_pkg::*;

	logic [TICK_W-1:0]  tick_q;
	logic [STATE_W-1:0] state_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [FREQ_W-1:0]  switches_q;
	logic               req_q;
	logic               updated_q;

	logic [FREQ_W-1:0]  lo, hi;
	logic [STEP_W-1:0]  st;
	logic [TICK_W-1:0]  tpu;
	logic [TICK_W-1:0]  tick_inc;
	logic [FREQ_W:0]    up_sum;
	logic [FREQ_W-1:0]  up_f, dn_f;
	logic [STATE_W-1:0] n_state;
	logic [FREQ_W-1:0]  n_freq;
	logic [FREQ_W-1:0]  n_switches;
	logic               n_req;

	// Registers written as zero behave as one.
	assign lo  = (cfg.floor_freq == '0) ? FREQ_W'(1) : cfg.floor_freq;
	assign hi  = (cfg.ceiling_freq == '0) ? FREQ_W'(1) : cfg.ceiling_freq;
	assign st  = (cfg.ramp_step == '0) ? STEP_W'(1) : cfg.ramp_step;
	assign tpu = (cfg.ticks_per_update == '0) ? TICK_W'(1) : cfg.ticks_per_update;

	assign tick_inc = tick_q + 1'b1;
	assign up_sum   = {1'b0, freq_q} + (FREQ_W + 1)'(st);
	assign up_f     = up_sum[FREQ_W] ? FREQ_MAX : up_sum[FREQ_W-1:0];
	assign dn_f     = (freq_q > FREQ_W'(st)) ? (freq_q - FREQ_W'(st)) : FREQ_W'(1);

	always_comb begin
		n_state    = state_q;
		n_freq     = freq_q;
		n_switches = switches_q;
		n_req      = req_q;
		case (state_q)
			RS_LOW: begin
				n_freq = lo;
				if (req_q) n_state = RS_UP;
			end
			RS_HIGH: begin
				n_freq = hi;
				if (req_q) n_state = RS_DOWN;
			end
			RS_DOWN: begin
				n_freq = dn_f;
				if (dn_f <= lo) begin
					n_state    = RS_LOW;
					n_switches = switches_q + 1'b1;
					n_req      = 1'b0;
				end
			end
			default: begin
				n_freq = up_f;
				if (up_f >= hi) begin
					n_state    = RS_HIGH;
					n_switches = switches_q + 1'b1;
					n_req      = 1'b0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			state_q    <= RS_LOW;
			freq_q     <= LOW_FREQ_RST;
			switches_q <= '0;
			req_q      <= 1'b0;
			updated_q  <= 1'b0;
		end else if (step) begin
			updated_q <= 1'b0;
			if (is_request) begin
				req_q <= 1'b1;
			end else if (tick_inc >= tpu) begin
				tick_q     <= '0;
				state_q    <= n_state;
				freq_q     <= n_freq;
				switches_q <= n_switches;
				req_q      <= n_req;
				updated_q  <= 1'b1;
			end else begin
				tick_q <= tick_inc;
			end
		end
	end

	assign stat = '{freq: freq_q, state: state_q, switches: switches_q,
		req: req_q, updated: updated_q};

`ifndef SYNTH
	a_freq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		freq_q != '0) else $error("ramp frequency reached zero");
	a_ramp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RS_UP || state_q == RS_DOWN) |-> req_q)
		else $error("ramp running without a pending request");
	a_request_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_request) |=> req_q) else $error("request not latched");
`endif

endmodule

// ===== rtl/core/pwm_frequency_ramp_controller.sv =====
// Top level of the PWM frequency ramp controller: channels, configuration, sequencer.
// Depends on prfc_pkg, prfc_ramp, prfc_serial_mul and prfc_serial_div.
//
//  Channel  | Direction | Signals                     | Contents (lowest bit first)
//  ---------+-----------+-----------------------------+-------------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata   | tdata: duty_percent[6:0], pad;
//           |           | s_tuser                     | tuser: mode (0 tick, 1 request)
//  m_       | out       | m_tvalid m_tready m_tdata   | period_count, compare_count,
//           |           |                             | frequency_hz, ramp_state,
//           |           |                             | switch_count, request_pending, pad
//  cfg_     | in        | cfg_we cfg_index cfg_wdata  | register write, no read-back
//
// Each transfer on s_ advances the ramp machine in its acceptance cycle. The compare value
// then takes a bit-serial multiply (7 partial products) and a serial divide by one
// hundred. A tick that triggers a ramp update adds a second serial divide for the new
// period. s_tready returns in the same cycle that the result enters the output register.
// The shared divider is DIV_W bits wide; with the default timer clock DIV_W is 27.
// Reset is asynchronous and active low and restores the control, configuration and ramp
// registers to their defaults; the datapath registers have no reset.
// The result sits in an output register, so the next item is accepted while it waits;
// s_tready is high only while the sequencer is idle.
module pwm_frequency_ramp_controller #(
	parameter int TIMER_CLOCK_HZ = prfc_pkg::TIMER_CLOCK_HZ_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // duty_percent[6:0], zero pad
	input  logic                               s_tuser,   // mode
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// period_count[19:0], compare_count[39:20], frequency_hz[55:40], ramp_state[57:56],
	// switch_count[73:58], request_pending[74], zero pad[79:75]
	output logic [79:0]                        m_tdata,
	// Configuration writes.
	input  logic                               cfg_we,
	input  logic [prfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prfc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import prfc_pkg::*;

	// Width of the timer clock constant and of the shared divider.
	localparam int TW     = $clog2(TIMER_CLOCK_HZ + 1);
	localparam int PROD_W = PERIOD_W + DUTY_W;
	localparam int DIV_W  = (TW > PROD_W) ? TW : PROD_W;
	localparam int RST_QUO = TIMER_CLOCK_HZ / int'(LOW_FREQ_RST);
	localparam logic [PERIOD_W-1:0] PERIOD_RST =
		(RST_QUO > int'(PERIOD_MAX)) ? PERIOD_MAX : PERIOD_W'(RST_QUO);

	// Sequencer states.
	localparam logic [2:0] SQ_IDLE = 3'd0;
	localparam logic [2:0] SQ_MUL  = 3'd1;
	localparam logic [2:0] SQ_DIVC = 3'd2;
	localparam logic [2:0] SQ_DIVP = 3'd3;
	localparam logic [2:0] SQ_DONE = 3'd4;

	logic [2:0]          sq_q;
	cfg_t                cfg_q;
	ramp_stat_t          stat;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] comp_q;
	logic                out_valid_q;
	logic [79:0]         out_data_q;

	logic                accept;
	logic [DUTY_W-1:0]   duty_in;
	logic [DUTY_W-1:0]   duty_clamped;
	logic                mul_done;
	logic [PROD_W-1:0]   product;
	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [FREQ_W-1:0]   div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    quotient;
	logic                out_free;

	assign s_tready = (sq_q == SQ_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign duty_in  = s_tdata[DUTY_W-1:0];
	// Duty above one hundred percent is treated as one hundred.
	assign duty_clamped = (duty_in > DUTY_MAX) ? DUTY_MAX : duty_in;
	assign out_free = !out_valid_q || m_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_freq       <= LOW_FREQ_RST;
			cfg_q.ceiling_freq     <= HIGH_FREQ_RST;
			cfg_q.ramp_step        <= RAMP_STEP_RST;
			cfg_q.ticks_per_update <= TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOW_FREQ:  cfg_q.floor_freq       <= cfg_wdata;
				CFG_HIGH_FREQ: cfg_q.ceiling_freq     <= cfg_wdata;
				CFG_RAMP_STEP: cfg_q.ramp_step        <= cfg_wdata[STEP_W-1:0];
				CFG_TICKS:     cfg_q.ticks_per_update <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	prfc_ramp u_ramp (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.is_request (s_tuser),
		.cfg        (cfg_q),
		.stat       (stat)
	);

	// The multiply uses the period held before this item, which gives the compare
	// value its one-update lag behind a new period.
	prfc_serial_mul #(.AW(PERIOD_W), .BW(DUTY_W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.a       (period_q),
		.b       (duty_clamped),
		.done    (mul_done),
		.product (product)
	);

	// One divider serves both the compare scaling and the period computation.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_W'(product);
		div_divisor  = PCT_DIVISOR;
		case (sq_q)
			SQ_MUL: begin
				div_start = mul_done;
			end
			SQ_DIVC: begin
				div_start    = div_done && stat.updated;
				div_dividend = DIV_W'(TIMER_CLOCK_HZ);
				div_divisor  = stat.freq;
			end
			default: ;
		endcase
	end

	prfc_serial_div #(.DW(DIV_W), .VW(FREQ_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q     <= SQ_IDLE;
			period_q <= PERIOD_RST;
		end else begin
			case (sq_q)
				SQ_IDLE: if (accept) sq_q <= SQ_MUL;
				SQ_MUL:  if (mul_done) sq_q <= SQ_DIVC;
				SQ_DIVC: if (div_done) sq_q <= stat.updated ? SQ_DIVP : SQ_DONE;
				SQ_DIVP: begin
					if (div_done) begin
						// The period saturates at the largest 20-bit value.
						period_q <= (quotient > DIV_W'(PERIOD_MAX)) ? PERIOD_MAX
							: quotient[PERIOD_W-1:0];
						sq_q <= SQ_DONE;
					end
				end
				SQ_DONE: if (out_free) sq_q <= SQ_IDLE;
				default: sq_q <= SQ_IDLE;
			endcase
		end
	end

	// The compare quotient never exceeds the old period, so its low bits hold it whole.
	always_ff @(posedge clk) begin
		if (sq_q == SQ_DIVC && div_done) comp_q <= quotient[PERIOD_W-1:0];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sq_q == SQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_q == SQ_DONE && out_free) begin
			out_data_q <= {5'b0, stat.req, stat.switches, stat.state, stat.freq,
				comp_q, period_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sq_q == SQ_MUL) else $error("accepted item did not start multiply");
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> sq_q == SQ_MUL) else $error("multiply finished outside its step");
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (sq_q == SQ_DIVC || sq_q == SQ_DIVP))
		else $error("divide finished outside its steps");
	a_out_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_q == SQ_DONE && !out_free) |=> (sq_q == SQ_DONE && out_valid_q))
		else $error("result left while output register was full");
`endif

endmodule
